// File: design/pld_pkg.sv
// Shared types and constants of the preset link command deframer.
`timescale 1ns / 1ps
package pld_pkg;

  // Frame magic bytes
  localparam logic [7:0] MagicB0     = 8'hF3;
  localparam logic [7:0] MagicB1     = 8'h0F;
  localparam logic [7:0] MagicB2     = 8'hAB;
  localparam logic [7:0] MagicNarrow = 8'hCA;
  localparam logic [7:0] MagicWide   = 8'hCB;

  // Command codes
  localparam logic [7:0] CmdGet = 8'd0;
  localparam logic [7:0] CmdSet = 8'd1;

  // Result kinds
  localparam logic [1:0] KindStoreByte  = 2'd0;
  localparam logic [1:0] KindBeginStore = 2'd1;
  localparam logic [1:0] KindStoreDone  = 2'd2;
  localparam logic [1:0] KindSendReq    = 2'd3;

  // Receive phases
  localparam logic [2:0] PhHunt0 = 3'd0;
  localparam logic [2:0] PhHunt1 = 3'd1;
  localparam logic [2:0] PhHunt2 = 3'd2;
  localparam logic [2:0] PhHunt3 = 3'd3;
  localparam logic [2:0] PhHdr   = 3'd4;
  localparam logic [2:0] PhData  = 3'd5;

  // Width of the packed tdata word of one result
  localparam int unsigned ResDataW = 80;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  preset_slot;
    logic [31:0] byte_offset;
    logic [7:0]  data_byte;
    logic [31:0] send_length;
    logic        wide_header;
    logic        from_ram;
    logic        last;
  } result_t;

  // Results produced by one accepted byte (0, 1 or 2)
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } result_pair_t;

endpackage

// File: design/pld_core.sv
// Frame hunt, header collection and result generation for one received byte.
`timescale 1ns / 1ps
module pld_core import pld_pkg::*; #(
  parameter int unsigned PRESET_COUNT = 32,
  parameter int unsigned PRESET_BYTES = 1552
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [4:0]   cfg_wdata_i,
  input  logic         byte_valid_i,
  input  logic [7:0]   byte_i,
  output result_pair_t res_o
);

  logic [2:0]  phase_q, phase_d;
  logic        wide_q, wide_d;
  logic [3:0]  hdr_cnt_q, hdr_cnt_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  slot_q, slot_d;
  logic [31:0] start_q, start_d;
  logic [31:0] len_q, len_d;
  logic [31:0] pay_cnt_q, pay_cnt_d;
  logic [4:0]  ram_idx_q;

  logic [3:0]  field_w;
  logic [1:0]  off_lane;
  logic [1:0]  len_lane;
  logic [31:0] len_upd;
  logic [31:0] pay_cnt_inc;
  logic [15:0] get_off16;
  logic [15:0] get_len16;
  result_t     base;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_idx_q <= '0;
    end else if (cfg_we_i) begin
      ram_idx_q <= cfg_wdata_i;
    end
  end

  // Header byte lanes and helpers
  assign field_w     = wide_q ? 4'd4 : 4'd2;
  assign off_lane    = 2'(hdr_cnt_q - 4'd2);
  assign len_lane    = 2'(hdr_cnt_q - 4'd2 - field_w);
  assign pay_cnt_inc = pay_cnt_q + 32'd1;
  assign get_off16   = start_q[15:0];
  assign get_len16   = 16'(PRESET_BYTES) - get_off16;

  always_comb begin
    len_upd = len_q;
    len_upd[8*len_lane +: 8] = byte_i;
  end

  // Common result fields
  always_comb begin
    base             = '0;
    base.preset_slot = slot_q[4:0];
    base.byte_offset = start_q;
    base.wide_header = wide_q;
  end

  // Advance the frame state and build the results
  always_comb begin
    phase_d   = phase_q;
    wide_d    = wide_q;
    hdr_cnt_d = hdr_cnt_q;
    cmd_d     = cmd_q;
    slot_d    = slot_q;
    start_d   = start_q;
    len_d     = len_q;
    pay_cnt_d = pay_cnt_q;
    res_o     = '0;
    if (byte_valid_i) begin
      case (phase_q)
        PhHunt0, PhHunt1, PhHunt2: begin
          if ((phase_q == PhHunt0 && byte_i == MagicB0) ||
              (phase_q == PhHunt1 && byte_i == MagicB1) ||
              (phase_q == PhHunt2 && byte_i == MagicB2)) begin
            phase_d = phase_q + 3'd1;
          end else begin
            phase_d = (byte_i == MagicB0) ? PhHunt1 : PhHunt0;
          end
        end
        PhHunt3: begin
          if (byte_i == MagicNarrow || byte_i == MagicWide) begin
            wide_d    = (byte_i == MagicWide);
            phase_d   = PhHdr;
            hdr_cnt_d = '0;
            start_d   = '0;
            len_d     = '0;
          end else begin
            phase_d = (byte_i == MagicB0) ? PhHunt1 : PhHunt0;
          end
        end
        PhHdr: begin
          hdr_cnt_d = hdr_cnt_q + 4'd1;
          if (hdr_cnt_q == 4'd0) begin
            cmd_d = byte_i;
          end else if (hdr_cnt_q == 4'd1) begin
            slot_d = byte_i;
          end else if (hdr_cnt_q < 4'd2 + field_w) begin
            start_d[8*off_lane +: 8] = byte_i;
          end else begin
            len_d = len_upd;
          end
          // Last length byte ends the header
          if (hdr_cnt_q == 4'd1 + (field_w << 1)) begin
            phase_d   = PhHunt0;
            hdr_cnt_d = '0;
            if ({1'b0, slot_q} >= 9'(PRESET_COUNT)) begin
              // slot out of range: drop the command
            end else if (cmd_q == CmdGet) begin
              res_o.count          = 2'd1;
              res_o.r0             = base;
              res_o.r0.kind        = KindSendReq;
              res_o.r0.send_length = len_upd;
              res_o.r0.from_ram    = (slot_q == {3'b000, ram_idx_q});
              res_o.r0.last        = 1'b1;
              if (len_upd == '0) begin
                // zero length: send rest of preset in narrow form
                res_o.r0.byte_offset = {16'd0, get_off16};
                res_o.r0.send_length = {16'd0, get_len16};
                res_o.r0.wide_header = 1'b0;
              end
            end else if (cmd_q == CmdSet) begin
              res_o.r0      = base;
              res_o.r0.kind = KindBeginStore;
              if (len_upd == '0) begin
                res_o.count   = 2'd2;
                res_o.r1      = base;
                res_o.r1.kind = KindStoreDone;
                res_o.r1.last = 1'b1;
              end else begin
                res_o.count   = 2'd1;
                res_o.r0.last = 1'b1;
                phase_d       = PhData;
                pay_cnt_d     = '0;
              end
            end else begin
              // unknown command: drop it
            end
          end
        end
        PhData: begin
          pay_cnt_d            = pay_cnt_inc;
          res_o.r0             = base;
          res_o.r0.kind        = KindStoreByte;
          res_o.r0.byte_offset = start_q + pay_cnt_q;
          res_o.r0.data_byte   = byte_i;
          if (pay_cnt_inc == len_q) begin
            res_o.count   = 2'd2;
            res_o.r1      = base;
            res_o.r1.kind = KindStoreDone;
            res_o.r1.last = 1'b1;
            phase_d       = PhHunt0;
            hdr_cnt_d     = '0;
          end else begin
            res_o.count   = 2'd1;
            res_o.r0.last = 1'b1;
          end
        end
        default: begin
          phase_d   = PhHunt0;
          hdr_cnt_d = '0;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt0;
      wide_q    <= 1'b0;
      hdr_cnt_q <= '0;
      cmd_q     <= '0;
      slot_q    <= '0;
      start_q   <= '0;
      len_q     <= '0;
      pay_cnt_q <= '0;
    end else begin
      phase_q   <= phase_d;
      wide_q    <= wide_d;
      hdr_cnt_q <= hdr_cnt_d;
      cmd_q     <= cmd_d;
      slot_q    <= slot_d;
      start_q   <= start_d;
      len_q     <= len_d;
      pay_cnt_q <= pay_cnt_d;
    end
  end

endmodule

// File: design/pld_result_fifo.sv
// Three-entry result queue taking up to two results per cycle, giving one.
`timescale 1ns / 1ps
module pld_result_fifo import pld_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  result_pair_t push_i,
  output logic         room_o,
  output logic         valid_o,
  input  logic         ready_i,
  output result_t      head_o
);

  result_t    mem_q [3];
  logic [1:0] wr_q, rd_q, cnt_q;
  logic [1:0] wr_next;
  logic       pop;

  function automatic logic [1:0] inc3(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  assign wr_next = inc3(wr_q);
  assign valid_o = (cnt_q != 2'd0);
  assign room_o  = (cnt_q <= 2'd1);
  assign pop     = valid_o && ready_i;
  assign head_o  = mem_q[rd_q];

  // Store incoming results
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i.count == 2'd1) begin
        wr_q <= wr_next;
      end else if (push_i.count == 2'd2) begin
        wr_q <= inc3(wr_next);
      end
      if (pop) begin
        rd_q <= inc3(rd_q);
      end
      cnt_q <= cnt_q + push_i.count - {1'b0, pop};
    end
  end

endmodule

// File: design/preset_link_command_deframer.sv
// Top level of the preset link command deframer.
//
// Usage: received link bytes enter on the s_axis channel, one byte per
// transfer. The block hunts for the frame magic, collects the command header
// and emits store-byte, begin-store, store-finished and send-request results
// on the m_axis channel; tuser carries the result kind, tlast marks the last
// result caused by one input byte. ram_preset_index is written through
// cfg_we_i / cfg_wdata_i, only while the block is idle: a rule for the user
// that the block does not enforce. Results are held in the result queue.
// Throughput: one byte per cycle while each byte yields at most one result
// and the sink takes every cycle; a byte that ends a store yields two results,
// and the three-entry result queue, which drains one result per cycle, holds
// s_axis_tready low until at most one result waits.
// Stall: s_axis_tready drops while two or more results wait in the queue;
// nothing is lost or dropped while m_axis_tready is low.
// Reset: the hunt restarts, the queue empties and ram_preset_index clears.
`timescale 1ns / 1ps
module preset_link_command_deframer import pld_pkg::*; #(
  parameter int unsigned PRESET_COUNT = 32,
  parameter int unsigned PRESET_BYTES = 1552
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [4:0] preset_slot, [36:5] byte_offset, [44:37] data_byte,
  // [76:45] send_length, [77] wide_header, [78] from_ram, [79] zero
  output logic [ResDataW-1:0] m_axis_tdata,
  output logic [1:0]          m_axis_tuser,   // [1:0] kind
  output logic                m_axis_tlast
);

  result_pair_t res;
  result_t      head;
  logic         room;
  logic         byte_accept;

  assign s_axis_tready = room;
  assign byte_accept   = s_axis_tvalid && room;

  pld_core #(
    .PRESET_COUNT(PRESET_COUNT),
    .PRESET_BYTES(PRESET_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_valid_i(byte_accept),
    .byte_i      (s_axis_tdata),
    .res_o       (res)
  );

  pld_result_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res),
    .room_o (room),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .head_o (head)
  );

  // Pack the head result onto the master side
  assign m_axis_tdata = {1'b0, head.from_ram, head.wide_header, head.send_length,
                         head.data_byte, head.byte_offset, head.preset_slot};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule
